@@ rtl/core/dmxr_pkg.sv @@
// ----------------------------------------------------------------------------
// dmxr_pkg
// Shared widths, limits and event codes of the DMX512 / RDM frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dmxr_pkg;

  localparam int unsigned MAX_SLOTS     = 512;
  localparam int unsigned RDM_BUF_BYTES = 60;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned SUM_W   = 16;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam event_t EV_NONE    = 3'd0;
  localparam event_t EV_BREAK   = 3'd1;
  localparam event_t EV_DMX     = 3'd2;
  localparam event_t EV_RDM     = 3'd3;
  localparam event_t EV_GOOD    = 3'd4;
  localparam event_t EV_BAD     = 3'd5;
  localparam event_t EV_OVF     = 3'd6;
  localparam event_t EV_UNKNOWN = 3'd7;

  localparam byte_t SC_DMX = 8'h00;
  localparam byte_t SC_RDM = 8'hCC;
  localparam byte_t SC_SUB = 8'h01;

endpackage

`default_nettype wire

@@ rtl/core/dmxr_if.sv @@
// ----------------------------------------------------------------------------
// dmxr_byte_if / dmxr_event_if
// Valid/ready channels for received UART bytes and receiver events.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmxr_byte_if;
  logic                valid;
  logic                ready;
  logic [7:0]          rx_byte;
  logic                frame_error;

  modport source (output valid, output rx_byte, output frame_error, input ready);
  modport sink   (input valid, input rx_byte, input frame_error, output ready);
endinterface

interface dmxr_event_if;
  logic                valid;
  logic                ready;
  logic [2:0]          event_res;
  logic [9:0]          slot_index;
  logic [7:0]          slot_value;
  logic [7:0]          rdm_length;

  modport source (output valid, output event_res, output slot_index,
                  output slot_value, output rdm_length, input ready);
  modport sink   (input valid, input event_res, input slot_index,
                  input slot_value, input rdm_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dmx_rdm_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// dmx_rdm_frame_receiver
// Parses a UART byte stream into DMX512 slots and RDM packets.
//
// Channels: uart carries one request per received byte (rx_byte plus
// frame_error; a framing error is a line break). evt carries one event per
// request: break, DMX slot, RDM byte, RDM good/bad with its length,
// overflow, unknown start code, or none (EV_NONE).
// cfg_we/cfg_wdata write last_slot (reset 512); clamped to 1..512, it is the
// highest DMX slot reported before the receiver waits for the next break.
// Output: a request's event is registered on acceptance and shows on evt in the next cycle.
// Throughput: one request per cycle while evt does not stall; the parse
// state and the event register update in the same cycle.
// Reset: the parser returns to idle, no event is pending, last_slot is 512.
// Stall: while evt holds an untaken event, uart.ready stays high only if
// evt.ready is high in that cycle, so a request is accepted exactly when
// the event register is free or drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rdm_frame_receiver (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire dmxr_pkg::index_t      cfg_wdata,
  dmxr_byte_if.sink                  uart,
  dmxr_event_if.source               evt
);
  import dmxr_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_BREAK = 3'd1;
  localparam logic [2:0] M_DMX   = 3'd2;
  localparam logic [2:0] M_RDM   = 3'd3;
  localparam logic [2:0] M_CSH   = 3'd4;
  localparam logic [2:0] M_CSL   = 3'd5;

  localparam index_t MAX_SLOTS_IDX = INDEX_W'(MAX_SLOTS);
  localparam index_t RDM_BUF_IDX   = INDEX_W'(RDM_BUF_BYTES);

  index_t     last_slot;
  logic [2:0] rx_mode, rx_mode_next;
  index_t     position, position_next;
  sum_t       running_sum, running_sum_next;
  byte_t      message_length, message_length_next;
  byte_t      sub_start, sub_start_next;
  logic       length_seen, length_seen_next;

  logic       out_valid;
  event_t     ev_next;
  index_t     idx_next;
  byte_t      val_next;
  byte_t      len_next;

  index_t     limit;
  index_t     pos_inc;
  logic       accept;

  assign uart.ready = !out_valid || evt.ready;
  assign accept     = uart.valid && uart.ready;
  assign pos_inc    = position + 1'b1;

  always_comb begin
    if (last_slot == '0) begin
      limit = index_t'(1);
    end else if (last_slot > MAX_SLOTS_IDX) begin
      limit = MAX_SLOTS_IDX;
    end else begin
      limit = last_slot;
    end
  end

  always_comb begin
    rx_mode_next        = rx_mode;
    position_next       = position;
    running_sum_next    = running_sum;
    message_length_next = message_length;
    sub_start_next      = sub_start;
    length_seen_next    = length_seen;
    ev_next             = EV_NONE;
    idx_next            = '0;
    val_next            = '0;
    len_next            = '0;

    if (uart.frame_error) begin
      rx_mode_next     = M_BREAK;
      position_next    = '0;
      length_seen_next = 1'b0;
      ev_next          = EV_BREAK;
    end else begin
      case (rx_mode)
        M_BREAK: begin
          if (uart.rx_byte == SC_DMX) begin
            rx_mode_next  = M_DMX;
            position_next = index_t'(1);
          end else if (uart.rx_byte == SC_RDM) begin
            rx_mode_next     = M_RDM;
            running_sum_next = {{(SUM_W-BYTE_W){1'b0}}, uart.rx_byte};
            position_next    = index_t'(1);
            ev_next          = EV_RDM;
            val_next         = uart.rx_byte;
          end else begin
            rx_mode_next = M_IDLE;
            ev_next      = EV_UNKNOWN;
            val_next     = uart.rx_byte;
          end
        end
        M_DMX: begin
          ev_next       = EV_DMX;
          idx_next      = position;
          val_next      = uart.rx_byte;
          position_next = pos_inc;
          if (pos_inc > limit) begin
            rx_mode_next = M_IDLE;
          end
        end
        M_RDM: begin
          if (position >= RDM_BUF_IDX) begin
            rx_mode_next = M_IDLE;
            ev_next      = EV_OVF;
          end else begin
            if (position == index_t'(1)) begin
              sub_start_next = uart.rx_byte;
            end
            if (position == index_t'(2)) begin
              message_length_next = uart.rx_byte;
              length_seen_next    = 1'b1;
            end
            ev_next          = EV_RDM;
            idx_next         = position;
            val_next         = uart.rx_byte;
            position_next    = pos_inc;
            running_sum_next = running_sum + {{(SUM_W-BYTE_W){1'b0}}, uart.rx_byte};
            if (length_seen_next &&
                pos_inc == {{(INDEX_W-BYTE_W){1'b0}}, message_length_next}) begin
              rx_mode_next = M_CSH;
            end
          end
        end
        M_CSH: begin
          running_sum_next = running_sum - {uart.rx_byte, {(SUM_W-BYTE_W){1'b0}}};
          rx_mode_next     = M_CSL;
        end
        M_CSL: begin
          running_sum_next = running_sum - {{(SUM_W-BYTE_W){1'b0}}, uart.rx_byte};
          rx_mode_next     = M_IDLE;
          len_next         = message_length;
          if (running_sum_next == '0 && sub_start == SC_SUB) begin
            ev_next = EV_GOOD;
          end else begin
            ev_next = EV_BAD;
          end
        end
        default: begin
          rx_mode_next = rx_mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot      <= MAX_SLOTS_IDX;
      rx_mode        <= M_IDLE;
      position       <= '0;
      running_sum    <= '0;
      message_length <= '0;
      sub_start      <= '0;
      length_seen    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_slot <= cfg_wdata;
      end
      if (accept) begin
        rx_mode        <= rx_mode_next;
        position       <= position_next;
        running_sum    <= running_sum_next;
        message_length <= message_length_next;
        sub_start      <= sub_start_next;
        length_seen    <= length_seen_next;
        out_valid      <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt.event_res  <= ev_next;
      evt.slot_index <= idx_next;
      evt.slot_value <= val_next;
      evt.rdm_length <= len_next;
    end
  end

  assign evt.valid = out_valid;

  a_break_event: assert property (@(posedge clk) disable iff (rst)
    accept && uart.frame_error |=> evt.valid && evt.event_res == EV_BREAK)
    else $error("break request did not produce a break event");

  a_rdm_bound: assert property (@(posedge clk) disable iff (rst)
    rx_mode == M_RDM |-> position <= RDM_BUF_IDX)
    else $error("RDM position beyond buffer");

  a_csh_length: assert property (@(posedge clk) disable iff (rst)
    rx_mode == M_CSH || rx_mode == M_CSL |-> length_seen)
    else $error("checksum phase without length byte");

  a_csl_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !uart.frame_error && rx_mode == M_CSL |=>
      rx_mode == M_IDLE && (evt.event_res == EV_GOOD || evt.event_res == EV_BAD))
    else $error("checksum low byte did not end the packet");

  // last_slot may drop mid-frame, so only the absolute slot range holds here
  a_dmx_limit: assert property (@(posedge clk) disable iff (rst)
    rx_mode == M_DMX |-> position <= MAX_SLOTS_IDX && position != '0)
    else $error("DMX slot index outside range");

endmodule

`default_nettype wire
